// ===== sv/adcma_pkg.sv =====
// ----------------------------------------------------------------------------
// adcma_pkg
// Shared constants for the converter moving-average block: field widths,
// default window length and the millivolt scaling constants.
// ----------------------------------------------------------------------------
`default_nettype none

package adcma_pkg;

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int MV_W     = 12;

  // Default window length (samples averaged once the ring has wrapped)
  localparam int WINDOW_DEF = 20;

  // Scaling: mv = mean * FULL_SCALE_MV / CODE_MAX
  localparam int FULL_SCALE_MV = 3300;
  localparam int CODE_MAX      = 4095;

  // mean (12 bits) times 3300 fits in 24 bits
  localparam int PROD_W = 2 * SAMPLE_W;

endpackage

`default_nettype wire

// ===== sv/adc_moving_average_to_millivolts_top.sv =====
// ----------------------------------------------------------------------------
// adc_moving_average_to_millivolts_top
// Boxcar moving average over a ring of WINDOW samples, scaled to millivolts.
// After a sample is accepted, a bit-serial restoring divide by the sample
// count yields one quotient bit per cycle from the SUM_W-bit running sum; the
// mean is then scaled, estimated and corrected in the MUL, EST and FIX steps.
// A new sample is taken only once the sequencer is back in idle; a finished
// result waits in the output register while the next item is taken, and a
// result still held there stalls the last step until it is taken.
// Reset clears position, wrap flag, running sum and control; the ring is not
// cleared (an entry is only read after it has been written).
// ----------------------------------------------------------------------------
`default_nettype none

module adc_moving_average_to_millivolts_top #(
  parameter int WINDOW = adcma_pkg::WINDOW_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         sample_valid,
  output logic                              sample_ready,
  input  wire logic [adcma_pkg::SAMPLE_W-1:0] adc_sample,
  output logic                              result_valid,
  input  wire logic                         result_ready,
  output logic [adcma_pkg::MV_W-1:0]        average_millivolts
);

  localparam int SW    = adcma_pkg::SAMPLE_W;
  localparam int PW    = adcma_pkg::PROD_W;
  localparam int SUM_W = $clog2(adcma_pkg::CODE_MAX * WINDOW + 1);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int STP_W = $clog2(SUM_W + 1);

  // Sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_EST  = 3'd3;
  localparam logic [2:0] ST_FIX  = 3'd4;

  logic [2:0]       state;
  logic [PTR_W-1:0] pos;
  logic             full;
  logic [SUM_W-1:0] sum;
  logic [SW-1:0]    ring [WINDOW];
  logic [SW-1:0]    old_sample;
  logic [CNT_W-1:0] divisor;
  logic [CNT_W-1:0] rem;
  logic [SUM_W-1:0] dvd;
  logic [STP_W-1:0] step;
  logic [PW-1:0]    prod;
  logic [SW-1:0]    q_est;

  logic             accept;
  logic [PTR_W:0]   pos_inc;
  logic             wrap;
  logic [SUM_W-1:0] sum_next;
  logic [CNT_W:0]   trial;
  logic             trial_ge;
  logic [PW:0]      est_sum;
  logic [PW:0]      fix_rem;
  logic             out_free;

  assign sample_ready = (state == ST_IDLE);
  assign accept       = sample_valid && sample_ready;
  assign out_free     = !result_valid || result_ready;

  // Position advance and wrap detect
  assign pos_inc = (PTR_W + 1)'(pos) + (PTR_W + 1)'(1);
  assign wrap    = (pos_inc == (PTR_W + 1)'(WINDOW));

  // Running sum upkeep: drop the overwritten entry once the ring is full
  always_comb begin
    sum_next = sum + SUM_W'(adc_sample);
    if (full) begin
      sum_next = sum_next - SUM_W'(old_sample);
    end
  end

  // Restoring divide step
  assign trial    = {rem, dvd[SUM_W-1]};
  assign trial_ge = (trial >= (CNT_W + 1)'(divisor));

  // Divide by 4095: estimate from shifts, then one correction
  assign est_sum = (PW + 1)'(prod) + (PW + 1)'(prod >> SW);
  assign fix_rem = (PW + 1)'(prod) + (PW + 1)'(q_est) - ((PW + 1)'(q_est) << SW);

  // Sample ring; the read port follows the write position
  always_ff @(posedge clk) begin
    if (accept) begin
      ring[pos] <= adc_sample;
    end
    old_sample <= ring[pos];
  end

  // Control and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      pos          <= '0;
      full         <= 1'b0;
      sum          <= '0;
      step         <= '0;
      result_valid <= 1'b0;
    end else begin
      // a new result loaded in the same cycle keeps valid high
      if (result_valid && result_ready && (state != ST_FIX)) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            sum     <= sum_next;
            dvd     <= sum_next;
            rem     <= '0;
            step    <= '0;
            pos     <= wrap ? '0 : pos_inc[PTR_W-1:0];
            full    <= full || wrap;
            divisor <= (full || wrap) ? CNT_W'(WINDOW) : CNT_W'(pos_inc);
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem  <= trial_ge ? CNT_W'(trial - (CNT_W + 1)'(divisor)) : trial[CNT_W-1:0];
          dvd  <= {dvd[SUM_W-2:0], trial_ge};
          step <= step + STP_W'(1);
          if (step == STP_W'(SUM_W - 1)) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= PW'(dvd[SW-1:0]) * PW'(adcma_pkg::FULL_SCALE_MV);
          state <= ST_EST;
        end
        ST_EST: begin
          q_est <= est_sum[2*SW-1:SW];
          state <= ST_FIX;
        end
        ST_FIX: begin
          if (out_free) begin
            average_millivolts <= (fix_rem >= (PW + 1)'(adcma_pkg::CODE_MAX))
                                  ? q_est + SW'(1) : q_est;
            result_valid       <= 1'b1;
            state              <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the converter moving-average block. A queue of
// samples is streamed into the block with random gaps while the result side
// stalls at random. An in-bench window model predicts the millivolt average
// of every accepted sample, and each accepted result is compared in order.
// ----------------------------------------------------------------------------

module testbench;

  localparam int WINDOW       = adcma_pkg::WINDOW_DEF;
  localparam int SAMPLE_W     = adcma_pkg::SAMPLE_W;
  localparam int MV_W         = adcma_pkg::MV_W;
  localparam int RANDOM_ITEMS = 1525;
  localparam int LATENCY      = 40;
  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_REPORTS  = 10;

  typedef enum int {
    BURST_ALL_HIGH,
    BURST_ALL_LOW,
    BURST_NEAR_TOP,
    BURST_NEAR_BOTTOM,
    BURST_STEADY,
    BURST_SEESAW,
    BURST_UNIFORM
  } burst_kind_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Block ports
  logic                sample_valid = 1'b0;
  logic                sample_ready;
  logic [SAMPLE_W-1:0] adc_sample   = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  logic [MV_W-1:0]     average_millivolts;

  adc_moving_average_to_millivolts_top #(
    .WINDOW(WINDOW)
  ) dut (
    .clk               (clk),
    .rst               (rst),
    .sample_valid      (sample_valid),
    .sample_ready      (sample_ready),
    .adc_sample        (adc_sample),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .average_millivolts(average_millivolts)
  );

  // Stimulus and scoreboard storage
  logic [SAMPLE_W-1:0] pending_samples[$];
  logic [MV_W-1:0]     expected_mv[$];
  int                  total_samples   = 0;
  int                  samples_taken   = 0;
  int                  results_checked = 0;
  int                  error_count     = 0;
  int                  report_count    = 0;
  int                  cycle_count     = 0;

  // Window model of the block
  logic [SAMPLE_W-1:0] window_ring[WINDOW];
  int unsigned         window_sum  = 0;
  int                  fill_pos    = 0;
  bit                  window_full = 1'b0;
  int                  wrap_count  = 0;

  // Folds one sample into the window and returns the averaged millivolts
  function automatic logic [MV_W-1:0] average_after_sample(logic [SAMPLE_W-1:0] s);
    int unsigned count;
    int unsigned mean;
    // oldest entry leaves the sum only once the ring has wrapped
    if (window_full) window_sum -= window_ring[fill_pos];
    window_sum += s;
    window_ring[fill_pos] = s;
    if (fill_pos == WINDOW - 1) begin
      fill_pos    = 0;
      window_full = 1'b1;
      wrap_count++;
    end else begin
      fill_pos++;
    end
    count = window_full ? WINDOW : fill_pos;
    mean  = window_sum / count;
    return MV_W'((mean * adcma_pkg::FULL_SCALE_MV) / adcma_pkg::CODE_MAX);
  endfunction

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Driver: sample side with random gaps between items
  int gap_left      = 0;
  bit sender_idles  = 1'b1;

  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
      gap_left     <= $urandom_range(0, 5);
    end else begin
      if (sample_valid && sample_ready) begin
        expected_mv.push_back(average_after_sample(adc_sample));
        samples_taken++;
      end
      // slot is free when nothing is held or the held item just went in
      if (!sample_valid || sample_ready) begin
        if (gap_left > 0) begin
          gap_left     <= gap_left - 1;
          sample_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          sample_valid <= 1'b1;
          adc_sample   <= pending_samples.pop_front();
          if ($urandom_range(0, 49) == 0) sender_idles = !sender_idles;
          gap_left     <= sender_idles ? $urandom_range(0, 5) : 0;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: result side, stalls a drawn number of cycles on each result
  int wait_left       = 0;
  bit receiver_stalls = 1'b1;
  int stall_draw;

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      wait_left    <= $urandom_range(0, 5);
    end else if (result_valid && result_ready) begin
      if (expected_mv.size() == 0) begin
        error_count++;
        if (report_count < MAX_REPORTS) begin
          report_count++;
          $display("unexpected result: got %0d mV with nothing pending",
                   average_millivolts);
        end
      end else begin
        if (average_millivolts !== expected_mv[0]) begin
          error_count++;
          if (report_count < MAX_REPORTS) begin
            report_count++;
            $display("mismatch on result %0d: expected %0d mV, got %0d mV",
                     results_checked, expected_mv[0], average_millivolts);
          end
        end
        void'(expected_mv.pop_front());
        results_checked++;
      end
      if ($urandom_range(0, 49) == 0) receiver_stalls = !receiver_stalls;
      stall_draw = receiver_stalls ? $urandom_range(0, 5) : 0;
      result_ready <= (stall_draw == 0);
      wait_left    <= stall_draw;
    end else if (!result_ready && result_valid) begin
      // count the stall down only while a result is being offered
      if (wait_left <= 1) result_ready <= 1'b1;
      wait_left <= wait_left - 1;
    end
  end

  // Stimulus, end of run and verdict
  initial begin
    burst_kind_t             kind;
    int                      burst_len;
    int                      queued;
    logic [SAMPLE_W-1:0]     steady_value;
    logic [SAMPLE_W-1:0]     value;
    int                      pick;

    // directed: a full window at the top code (partial counts, then full
    // scale), then the bottom code and bit patterns with the ring wrapped
    repeat (WINDOW) pending_samples.push_back(12'hFFF);
    pending_samples.push_back(12'h000);
    pending_samples.push_back(12'hAAA);
    pending_samples.push_back(12'h555);
    pending_samples.push_back(12'h001);
    pending_samples.push_back(12'h800);

    // random: bursts of mixed character, half of them uniform
    queued = 0;
    while (queued < RANDOM_ITEMS) begin
      pick         = $urandom_range(0, 11);
      kind         = (pick >= BURST_UNIFORM) ? BURST_UNIFORM : burst_kind_t'(pick);
      burst_len    = $urandom_range(5, 3 * WINDOW);
      steady_value = SAMPLE_W'($urandom_range(0, 4095));
      for (int k = 0; k < burst_len; k++) begin
        case (kind)
          BURST_ALL_HIGH:    value = 12'hFFF;
          BURST_ALL_LOW:     value = 12'h000;
          BURST_NEAR_TOP:    value = SAMPLE_W'(12'hFFF - $urandom_range(0, 15));
          BURST_NEAR_BOTTOM: value = SAMPLE_W'($urandom_range(0, 15));
          BURST_STEADY:      value = steady_value;
          BURST_SEESAW:      value = (k % 2) ? 12'hFFF : 12'h000;
          default:           value = SAMPLE_W'($urandom_range(0, 4095));
        endcase
        pending_samples.push_back(value);
      end
      queued += burst_len;
    end
    total_samples = pending_samples.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (!(samples_taken == total_samples && expected_mv.size() == 0)
           && cycle_count < LIMIT_CYCLES)
      @(posedge clk);

    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d of %0d samples taken",
               cycle_count, samples_taken, total_samples);
      $display("status: fail");
    end else begin
      // let any stray result show up before the verdict
      repeat (LATENCY) @(posedge clk);
      error_count += expected_mv.size();
      $display("run covered %0d samples, %0d millivolt results checked",
               total_samples, results_checked);
      $display("window wrapped %0d times, %0d errors", wrap_count, error_count);
      if (error_count == 0) begin
        $display("status: pass");
      end else begin
        $display("status: fail");
      end
    end
    $finish;
  end

endmodule
